/* hw/rtl/nearest_neighbour_point_ordering_unit_defines.svh */
// ----------------------------------------------------------------------------
// nearest_neighbour_point_ordering_unit_defines
// assertion macros for the point ordering unit
// ----------------------------------------------------------------------------
`ifndef NEAREST_NEIGHBOUR_POINT_ORDERING_UNIT_DEFINES_SVH
`define NEAREST_NEIGHBOUR_POINT_ORDERING_UNIT_DEFINES_SVH

// implication checked on every edge outside reset
`define NNPO_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication checked outside reset
`define NNPO_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/nnpo_pkg.sv */
// ----------------------------------------------------------------------------
// nnpo_pkg
// shared constants and types of the point ordering unit
// ----------------------------------------------------------------------------
package nnpo_pkg;

  localparam int unsigned MaxPointsDef = 64;
  localparam int unsigned CoordBitsDef = 24;
  localparam int unsigned IdxW         = 6;
  localparam int unsigned CfgIdxW      = 2;
  localparam int unsigned CfgDataW     = 24;

  localparam logic [CfgIdxW-1:0] CfgStartX = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgStartY = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgStartZ = 2'd2;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SEED,
    ST_SCAN,
    ST_WAIT,
    ST_EMIT
  } nnpo_state_t;

  // control from the sequencer to every cell
  typedef struct packed {
    logic load;   // store the incoming point in the cell picked by load_sel
    logic clear;  // drop all points and visited marks
    logic seed;   // take the reference point from the start position
    logic visit;  // mark the winner and make it the new reference
  } nnpo_ctrl_t;

endpackage

/* hw/rtl/nearest_neighbour_point_ordering_unit.sv */
// ----------------------------------------------------------------------------
// nearest_neighbour_point_ordering_unit
// greedy nearest-neighbor visiting order over a set of stored 3D points
// ----------------------------------------------------------------------------
// channel  direction  fields
// in_      request    px, py, pz, final_point
// out_     request    point_index, end_of_order
// cfg_     write      start_x, start_y, start_z by index
//
// loading takes one point per cycle; the final point starts ordering
// each emitted index takes a scan (squaring stage, one compare stage per
// cell, one spare), a winner step and an output step; the first index
// adds a seed step
// a stalled output holds the sequencer; no input is taken while ordering
// reset (rst_n low, synchronous) empties the store and the visited marks
module nearest_neighbour_point_ordering_unit #(
  parameter int unsigned MaxPoints = nnpo_pkg::MaxPointsDef,
  parameter int unsigned CoordBits = nnpo_pkg::CoordBitsDef
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [nnpo_pkg::CfgIdxW-1:0]         cfg_index,
  input  logic [CoordBits-1:0]                 cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [CoordBits-1:0]          in_px,
  input  logic signed [CoordBits-1:0]          in_py,
  input  logic signed [CoordBits-1:0]          in_pz,
  input  logic                                 in_final_point,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [nnpo_pkg::IdxW-1:0]            out_point_index,
  output logic                                 out_end_of_order
);
  import nnpo_pkg::*;

  `include "nearest_neighbour_point_ordering_unit_defines.svh"

  localparam int unsigned DistBits = 2 * CoordBits + 4;
  localparam int unsigned CntBits  = $clog2(MaxPoints + 1);
  localparam int unsigned LatBits  = $clog2(MaxPoints + 3);
  localparam logic [LatBits-1:0] ScanLat = LatBits'(MaxPoints + 1);

  // start position registers
  logic signed [CoordBits-1:0] sx_r, sy_r, sz_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sx_r <= '0;
      sy_r <= '0;
      sz_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CfgStartX: sx_r <= cfg_data;
        CfgStartY: sy_r <= cfg_data;
        CfgStartZ: sz_r <= cfg_data;
        default: ;
      endcase
    end
  end

  nnpo_state_t           state_r, state_nxt;
  logic [CntBits-1:0]    count_r, count_nxt;
  logic [CntBits-1:0]    left_r, left_nxt;
  logic [LatBits-1:0]    timer_r, timer_nxt;
  logic [IdxW-1:0]       oidx_r, oidx_nxt;
  logic                  oend_r, oend_nxt;
  logic signed [CoordBits-1:0] rx_r, ry_r, rz_r;
  nnpo_ctrl_t            ctrl;
  logic                  in_fire, out_fire;

  logic                  cf   [MaxPoints+1];
  logic [DistBits-1:0]   cd   [MaxPoints+1];
  logic [IdxW-1:0]       ci   [MaxPoints+1];
  logic signed [CoordBits-1:0] px_a [MaxPoints];
  logic signed [CoordBits-1:0] py_a [MaxPoints];
  logic signed [CoordBits-1:0] pz_a [MaxPoints];

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_LOAD: if (in_fire && in_final_point) state_nxt = ST_SEED;
      ST_SEED: state_nxt = ST_SCAN;
      ST_SCAN: if (timer_r == ScanLat) state_nxt = ST_WAIT;
      ST_WAIT: state_nxt = ST_EMIT;
      ST_EMIT: if (out_fire) state_nxt = (left_r == CntBits'(1)) ? ST_LOAD : ST_SCAN;
      default: state_nxt = ST_LOAD;
    endcase
  end

  // outputs and datapath control
  always_comb begin
    ctrl      = '0;
    in_ready  = (state_r == ST_LOAD);
    out_valid = (state_r == ST_EMIT);
    count_nxt = count_r;
    left_nxt  = left_r;
    timer_nxt = timer_r;
    oidx_nxt  = oidx_r;
    oend_nxt  = oend_r;
    case (state_r)
      ST_LOAD: begin
        if (in_fire) begin
          ctrl.load = (count_r < CntBits'(MaxPoints));
          if (ctrl.load) count_nxt = count_r + 1'b1;
          if (in_final_point) left_nxt = ctrl.load ? count_r + 1'b1 : count_r;
        end
      end
      ST_SEED: begin
        ctrl.seed = 1'b1;
        timer_nxt = '0;
      end
      ST_SCAN: timer_nxt = timer_r + 1'b1;
      ST_WAIT: begin
        ctrl.visit = 1'b1;
        oidx_nxt   = ci[MaxPoints];
        oend_nxt   = (left_r == CntBits'(1));
      end
      ST_EMIT: begin
        if (out_fire) begin
          timer_nxt = '0;
          left_nxt  = left_r - 1'b1;
          if (left_r == CntBits'(1)) begin
            ctrl.clear = 1'b1;
            count_nxt  = '0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      count_r <= '0;
      left_r  <= '0;
      timer_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      left_r  <= left_nxt;
      timer_r <= timer_nxt;
    end
  end

  always_ff @(posedge clk) begin
    oidx_r <= oidx_nxt;
    oend_r <= oend_nxt;
  end

  assign out_point_index  = oidx_r;
  assign out_end_of_order = oend_r;

  // reference point: start position, then each winner
  always_ff @(posedge clk) begin
    if (ctrl.seed) begin
      rx_r <= sx_r;
      ry_r <= sy_r;
      rz_r <= sz_r;
    end else if (ctrl.visit) begin
      rx_r <= px_a[ci[MaxPoints][$clog2(MaxPoints)-1:0]];
      ry_r <= py_a[ci[MaxPoints][$clog2(MaxPoints)-1:0]];
      rz_r <= pz_a[ci[MaxPoints][$clog2(MaxPoints)-1:0]];
    end
  end

  // chain head: nothing found yet
  assign cf[0] = 1'b0;
  assign cd[0] = '0;
  assign ci[0] = '0;

  // row of point cells
  for (genvar g = 0; g < MaxPoints; g++) begin : g_cell
    nnpo_cell #(
      .CoordBits(CoordBits),
      .IdxBits  (IdxW),
      .DistBits (DistBits)
    ) u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .ctrl         (ctrl),
      .load_sel     (count_r == CntBits'(g)),
      .my_idx       (IdxW'(g)),
      .pt_x         (in_px),
      .pt_y         (in_py),
      .pt_z         (in_pz),
      .ref_x        (rx_r),
      .ref_y        (ry_r),
      .ref_z        (rz_r),
      .win_idx      (ci[MaxPoints]),
      .cmp_in_found (cf[g]),
      .cmp_in_dist  (cd[g]),
      .cmp_in_idx   (ci[g]),
      .cmp_out_found(cf[g+1]),
      .cmp_out_dist (cd[g+1]),
      .cmp_out_idx  (ci[g+1]),
      .cur_x        (px_a[g]),
      .cur_y        (py_a[g]),
      .cur_z        (pz_a[g])
    );
  end

  `NNPO_ASSERT_IMPL(a_no_in_when_busy, state_r != ST_LOAD, !in_ready, "input taken while ordering")
  `NNPO_ASSERT_IMPL(a_winner_found, state_r == ST_WAIT, cf[MaxPoints], "scan found no point")
  `NNPO_ASSERT_IMPL(a_count_bound, 1'b1, count_r <= CntBits'(MaxPoints), "point count overflow")
  `NNPO_ASSERT_NEXT(a_last_clears, out_fire && out_end_of_order, count_r == '0 && state_r == ST_LOAD, "set not cleared")

endmodule

/* hw/rtl/nnpo_cell.sv */
// ----------------------------------------------------------------------------
// nnpo_cell
// one point cell: stores a point, squares its distance to the reference
// point and folds it into the running minimum passed along the chain
// ----------------------------------------------------------------------------
module nnpo_cell #(
  parameter int unsigned CoordBits = nnpo_pkg::CoordBitsDef,
  parameter int unsigned IdxBits   = nnpo_pkg::IdxW,
  parameter int unsigned DistBits  = 2 * CoordBits + 4
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  nnpo_pkg::nnpo_ctrl_t        ctrl,
  input  logic                        load_sel,
  input  logic [IdxBits-1:0]          my_idx,
  input  logic signed [CoordBits-1:0] pt_x,
  input  logic signed [CoordBits-1:0] pt_y,
  input  logic signed [CoordBits-1:0] pt_z,
  input  logic signed [CoordBits-1:0] ref_x,
  input  logic signed [CoordBits-1:0] ref_y,
  input  logic signed [CoordBits-1:0] ref_z,
  input  logic [IdxBits-1:0]          win_idx,
  input  logic                        cmp_in_found,
  input  logic [DistBits-1:0]         cmp_in_dist,
  input  logic [IdxBits-1:0]          cmp_in_idx,
  output logic                        cmp_out_found,
  output logic [DistBits-1:0]         cmp_out_dist,
  output logic [IdxBits-1:0]          cmp_out_idx,
  output logic signed [CoordBits-1:0] cur_x,
  output logic signed [CoordBits-1:0] cur_y,
  output logic signed [CoordBits-1:0] cur_z
);
  import nnpo_pkg::*;

  localparam int unsigned DiffBits = CoordBits + 1;
  localparam int unsigned SqBits   = 2 * DiffBits;

  logic signed [CoordBits-1:0] x_r, y_r, z_r;
  logic                        used_r, used_nxt;
  logic                        seen_r, seen_nxt;
  logic [SqBits-1:0]           sqx_r, sqy_r, sqz_r;
  logic                        cand_r;
  logic                        found_r;
  logic [DistBits-1:0]         dist_r;
  logic [IdxBits-1:0]          idx_r;
  logic signed [DiffBits-1:0]  dx, dy, dz;
  logic [DistBits-1:0]         my_dist;
  logic                        take;

  // point storage
  always_ff @(posedge clk) begin
    if (ctrl.load && load_sel) begin
      x_r <= pt_x;
      y_r <= pt_y;
      z_r <= pt_z;
    end
  end

  // occupancy and visited marks
  always_comb begin
    used_nxt = used_r;
    seen_nxt = seen_r;
    if (ctrl.clear) begin
      used_nxt = 1'b0;
      seen_nxt = 1'b0;
    end else if (ctrl.load && load_sel) begin
      used_nxt = 1'b1;
    end else if (ctrl.visit && win_idx == my_idx) begin
      seen_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= 1'b0;
      seen_r <= 1'b0;
    end else begin
      used_r <= used_nxt;
      seen_r <= seen_nxt;
    end
  end

  // squared axis differences, one multiplier per axis
  assign dx = DiffBits'(x_r) - DiffBits'(ref_x);
  assign dy = DiffBits'(y_r) - DiffBits'(ref_y);
  assign dz = DiffBits'(z_r) - DiffBits'(ref_z);

  always_ff @(posedge clk) begin
    sqx_r  <= SqBits'(dx * dx);
    sqy_r  <= SqBits'(dy * dy);
    sqz_r  <= SqBits'(dz * dz);
    cand_r <= used_r && !seen_r;
  end

  assign my_dist = DistBits'(sqx_r) + DistBits'(sqy_r) + DistBits'(sqz_r);

  // strict less keeps the lower index on ties
  assign take = cand_r && (!cmp_in_found || my_dist < cmp_in_dist);

  always_ff @(posedge clk) begin
    found_r <= cmp_in_found || cand_r;
    dist_r  <= take ? my_dist : cmp_in_dist;
    idx_r   <= take ? my_idx : cmp_in_idx;
  end

  assign cmp_out_found = found_r;
  assign cmp_out_dist  = dist_r;
  assign cmp_out_idx   = idx_r;

  // winner coordinates for the next reference
  assign cur_x = x_r;
  assign cur_y = y_r;
  assign cur_z = z_r;

endmodule

/* test/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// point ordering unit: sets of points go in, visiting orders come out
// ----------------------------------------------------------------------------
// each accepted point is noted by a scoreboard that keeps its own copy of the
// store and start position; a final point makes it work out the greedy order,
// which is then compared with every index the unit emits
// ----------------------------------------------------------------------------
module testbench;
  import nnpo_pkg::*;

  localparam int unsigned Points    = MaxPointsDef;
  localparam int unsigned Cw        = CoordBitsDef;
  localparam logic [CfgIdxW-1:0] CfgSpare = 2'd3;
  localparam int unsigned DrainWait = 2 * (Points + 2) + 20;
  localparam logic signed [Cw-1:0] CoordMax = {1'b0, {(Cw-1){1'b1}}};
  localparam logic signed [Cw-1:0] CoordMin = {1'b1, {(Cw-1){1'b0}}};

  typedef logic signed [Cw-1:0] coord_t;

  // predictor and store of expected indexes
  class order_scoreboard;
    coord_t start_pos[3];
    coord_t store_x[Points], store_y[Points], store_z[Points];
    int stored;
    logic [IdxW:0] expected_order[$];
    int errors, results, sets, largest;

    function new();
      start_pos = '{default: '0};
      stored = 0;
      errors = 0;
      results = 0;
      sets = 0;
      largest = 0;
    endfunction

    function void write_start(logic [CfgIdxW-1:0] idx, coord_t v);
      case (idx)
        CfgStartX: start_pos[0] = v;
        CfgStartY: start_pos[1] = v;
        CfgStartZ: start_pos[2] = v;
        default: ;
      endcase
    endfunction

    function longint dist_sq(coord_t ax, coord_t ay, coord_t az,
                             coord_t bx, coord_t by, coord_t bz);
      longint dx, dy, dz;
      dx = longint'(ax) - longint'(bx);
      dy = longint'(ay) - longint'(by);
      dz = longint'(az) - longint'(bz);
      return dx * dx + dy * dy + dz * dz;
    endfunction

    // store the point; a final point builds the whole visiting order
    function void note_request(coord_t x, coord_t y, coord_t z, logic fin);
      bit visited[Points];
      coord_t rx, ry, rz;
      int best;
      longint best_d, d;
      logic [IdxW:0] entry;
      if (stored < Points) begin
        store_x[stored] = x;
        store_y[stored] = y;
        store_z[stored] = z;
        stored++;
      end
      if (!fin) return;
      visited = '{default: 1'b0};
      rx = start_pos[0];
      ry = start_pos[1];
      rz = start_pos[2];
      for (int k = 0; k < stored; k++) begin
        best = -1;
        best_d = 0;
        for (int i = 0; i < stored; i++) begin
          if (visited[i]) continue;
          d = dist_sq(store_x[i], store_y[i], store_z[i], rx, ry, rz);
          // strict compare keeps the lowest index on a tie
          if (best < 0 || d < best_d) begin
            best = i;
            best_d = d;
          end
        end
        visited[best] = 1'b1;
        rx = store_x[best];
        ry = store_y[best];
        rz = store_z[best];
        entry = {(k == stored - 1), best[IdxW-1:0]};
        expected_order = {expected_order, entry};
      end
      sets++;
      if (stored > largest) largest = stored;
      stored = 0;
    endfunction

    task report_mismatch(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(logic [IdxW-1:0] idx, logic eoo);
      logic [IdxW:0] want;
      results++;
      if (expected_order.size() == 0) begin
        report_mismatch($sformatf("unexpected index %0d", idx));
        return;
      end
      want = expected_order.pop_front();
      if (idx !== want[IdxW-1:0])
        report_mismatch($sformatf("point_index %0d, expected %0d", idx, want[IdxW-1:0]));
      if (eoo !== want[IdxW])
        report_mismatch($sformatf("end_of_order %0b, expected %0b", eoo, want[IdxW]));
    endtask

    function int pending();
      return expected_order.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CfgIdxW-1:0] cfg_index;
  logic [Cw-1:0] cfg_data;
  logic in_valid, in_ready, in_final_point;
  coord_t in_px, in_py, in_pz;
  logic out_valid, out_ready, out_end_of_order;
  logic [IdxW-1:0] out_point_index;

  order_scoreboard sb = new();
  bit quiet = 1'b0;
  bit hold_request = 1'b0;
  int items = 0;

  nearest_neighbour_point_ordering_unit dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_px(in_px), .in_py(in_py), .in_pz(in_pz), .in_final_point(in_final_point),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_point_index(out_point_index), .out_end_of_order(out_end_of_order)
  );

  always #2 clk = ~clk;

  // sample both channels
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready)
      sb.note_request(in_px, in_py, in_pz, in_final_point);
    if (rst_n && out_valid && out_ready)
      sb.check_result(out_point_index, out_end_of_order);
  end

  // result receiver: random stall bursts, plus a long hold-off on demand
  initial begin
    int stall_left, hold_left;
    stall_left = 0;
    hold_left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        out_ready = 1'b0;
        hold_left--;
      end else if (quiet) begin
        out_ready = 1'b1;
      end else if (stall_left > 0) begin
        out_ready = 1'b0;
        stall_left--;
      end else if ($urandom_range(0, 7) == 0) begin
        out_ready = 1'b0;
        stall_left = $urandom_range(0, 10);
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  initial begin
    #2000000;
    $display("timeout");
    $display("FAIL");
    $finish;
  end

  task automatic write_cfg(logic [CfgIdxW-1:0] idx, coord_t v);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = v;
    sb.write_start(idx, v);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // offer one point and hold it until taken; called at a falling edge
  task automatic send_point(coord_t x, coord_t y, coord_t z, logic fin);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    in_valid = 1'b1;
    in_px = x;
    in_py = y;
    in_pz = z;
    in_final_point = fin;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items++;
    @(negedge clk);
  endtask

  // stop offering and let every expected index come out
  task automatic wait_idle();
    in_valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (DrainWait) @(negedge clk);
  endtask

  function automatic coord_t pick_coord(int mode);
    case (mode)
      0: return coord_t'($urandom);
      1: return coord_t'($urandom_range(0, 4)) - 2;
      default: begin
        case ($urandom_range(0, 4))
          0: return CoordMax;
          1: return CoordMin;
          2: return '0;
          3: return '1;
          default: return 1;
        endcase
      end
    endcase
  endfunction

  task automatic send_set(int size, int mode);
    for (int i = 0; i < size; i++)
      send_point(pick_coord(mode), pick_coord(mode), pick_coord(mode), i == size - 1);
  endtask

  initial begin
    int size, mode, phase;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CfgStartX;
    cfg_data = '0;
    in_valid = 1'b0;
    in_px = '0;
    in_py = '0;
    in_pz = '0;
    in_final_point = 1'b0;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    // directed: single point, extremes, duplicates that tie
    write_cfg(CfgSpare, CoordMax);
    send_point(CoordMax, CoordMin, CoordMax, 1'b1);
    send_point(CoordMax, CoordMax, CoordMax, 1'b0);
    send_point(CoordMin, CoordMin, CoordMin, 1'b0);
    send_point('0, '0, '0, 1'b0);
    send_point('0, '0, '0, 1'b0);
    send_point(1, -1, 0, 1'b1);
    wait_idle();
    write_cfg(CfgStartX, CoordMin);
    write_cfg(CfgStartY, CoordMin);
    write_cfg(CfgStartZ, CoordMin);
    send_point(CoordMax, CoordMax, CoordMax, 1'b0);
    send_point(CoordMin, CoordMin, CoordMin, 1'b0);
    send_point(CoordMin, CoordMin, CoordMin, 1'b0);
    send_point(CoordMax, CoordMin, '0, 1'b1);
    wait_idle();
    write_cfg(CfgStartX, CoordMax);
    write_cfg(CfgStartY, CoordMax);
    write_cfg(CfgStartZ, CoordMax);
    send_set(6, 2);
    wait_idle();
    write_cfg(CfgStartX, '0);
    write_cfg(CfgStartY, '0);
    write_cfg(CfgStartZ, '0);

    // random sets, mostly small; two full stores and an overfull one
    phase = 0;
    while (items < 480) begin
      phase++;
      if (items > 420) quiet = 1'b1;
      mode = $urandom_range(0, 2);
      if (phase == 3) size = Points + 3;
      else if (phase == 9 || phase == 30) size = Points;
      else size = $urandom_range(1, 8);
      // long receiver hold while further sets keep coming
      if (phase == 12) hold_request = 1'b1;
      send_set(size, mode);
      if ($urandom_range(0, 9) == 0 && !quiet) begin
        wait_idle();
        for (int r = 0; r < 3; r++)
          write_cfg(r[CfgIdxW-1:0], $urandom_range(0, 3) == 0 ? pick_coord(2) : pick_coord(0));
      end
    end

    in_valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (DrainWait) @(negedge clk);
    $display("covered %0d points in %0d sets, %0d indexes checked, largest set %0d",
             items, sb.sets, sb.results, sb.largest);
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/nnpo_pkg.sv
hw/rtl/nnpo_cell.sv
hw/rtl/nearest_neighbour_point_ordering_unit.sv
test/testbench.sv
